// ----- hw/rtl/gwci_pkg.sv -----
// ----------------------------------------------------------------------------
// gwci_pkg
// Shared types and constants for the grid wall cost inflation block.
// ----------------------------------------------------------------------------
package gwci_pkg;

  // Largest grid that the cost store holds.
  localparam int unsigned MAX_WIDTH  = 64;
  localparam int unsigned MAX_HEIGHT = 64;

  localparam int unsigned XW     = $clog2(MAX_WIDTH);
  localparam int unsigned YW     = $clog2(MAX_HEIGHT);
  localparam int unsigned AW     = XW + YW;
  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  // Field widths of the stream and configuration ports.
  localparam int unsigned DIM_W  = 7;
  localparam int unsigned COST_W = 16;
  localparam int unsigned OUT_W  = 17;

  // Occupancy byte that marks a wall.
  localparam logic [7:0] WALL_MARK = 8'd100;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WALL   = 2'd2,
    CFG_DECAY  = 2'd3
  } cfg_idx_e;

  // Cost left after one step of decay, floored at zero.
  function automatic logic [COST_W-1:0] decayed(input logic [COST_W-1:0] v,
                                                input logic [COST_W-1:0] decay);
    decayed = (v > decay) ? v - decay : '0;
  endfunction

endpackage

// ----- hw/rtl/gwci_ram.sv -----
// ----------------------------------------------------------------------------
// gwci_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module gwci_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/grid_wall_cost_inflation.sv -----
// ----------------------------------------------------------------------------
// grid_wall_cost_inflation
// Grid cost store with wall loading, two-pass raster inflation and queries.
// ----------------------------------------------------------------------------
// Sequence: a load or an unused command gives its result straight from the
// output register; a query goes through the query state, then that register.
// A compute runs the forward pass, the middle state, the backward pass and the
// end state (only the end state for an empty grid), one cell update per cycle in each raster pass.
// Throughput: one command at a time; the next is taken when its result is out.
// Reset: control and configuration clear at once (64 x 64 grid, zero costs of
// walls and decay); the cost store holds nothing valid until loaded.
// ----------------------------------------------------------------------------
module grid_wall_cost_inflation
  import gwci_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: col[5:0], row[13:6], col_off[14], occupancy[22:15], zeros above.
  input  logic [23:0] s_axis_tdata_i,
  // tuser: command[1:0].
  input  logic [1:0]  s_axis_tuser_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: cell_cost[16:0], zeros above.
  output logic [23:0] m_axis_tdata_o,
  // tuser: out_of_bounds[0].
  output logic [0:0]  m_axis_tuser_o,
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Sequencer states. The forward and backward passes each issue one cell per
  // cycle; the middle and end states let the last update of a pass land in
  // the store before anything reads it again.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_QUERY = 6'b000010,
    ST_FWD   = 6'b000100,
    ST_MID   = 6'b001000,
    ST_BWD   = 6'b010000,
    ST_END   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [DIM_W-1:0]  grid_width_q, grid_height_q;
  logic [COST_W-1:0] wall_cost_q, cost_decay_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DIM_W'(MAX_WIDTH);
      grid_height_q <= DIM_W'(MAX_HEIGHT);
      wall_cost_q   <= '0;
      cost_decay_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  grid_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: grid_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_WALL:   wall_cost_q   <= cfg_data_i;
        CFG_DECAY:  cost_decay_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sizes in use: anything above the store's size counts as the full size.
  logic [DIM_W-1:0] w_eff, h_eff, w_last, h_last;
  assign w_eff  = (grid_width_q  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : grid_width_q;
  assign h_eff  = (grid_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : grid_height_q;
  assign w_last = w_eff - DIM_W'(1);
  assign h_last = h_eff - DIM_W'(1);

  // Unpacked command fields.
  logic [1:0] in_cmd;
  logic [5:0] in_col;
  logic [7:0] in_row;
  logic       in_col_off;
  logic [7:0] in_occ;
  assign in_cmd     = s_axis_tuser_i;
  assign in_col     = s_axis_tdata_i[5:0];
  assign in_row     = s_axis_tdata_i[13:6];
  assign in_col_off = s_axis_tdata_i[14];
  assign in_occ     = s_axis_tdata_i[22:15];

  // The column and row lie inside the grid in use. A negative row fails on
  // its sign bit; otherwise its low bits hold the whole value.
  logic col_in, row_in;
  assign col_in = DIM_W'(in_col) < w_eff;
  assign row_in = !in_row[7] && (in_row[DIM_W-1:0] < h_eff);

  // Result register, which parts the output side from the sequencer.
  logic              out_vld_q, out_vld_d;
  logic [OUT_W-1:0]  out_cost_q, out_cost_d;
  logic              out_oob_q, out_oob_d;
  logic              out_free;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // Query bookkeeping between the transfer and the store's read data.
  logic q_oob_q, q_oob_d;

  // Raster counters and the update stage of the inflation passes.
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;

  logic          stg_vld_q, stg_vld_d;
  logic [AW-1:0] stg_addr_q, stg_addr_d;
  logic          stg_side_q, stg_side_d;
  logic          stg_vert_q, stg_vert_d;
  logic [COST_W-1:0] prev_q, prev_d;

  // Two mirrored copies of the cost store: both take every write, so each
  // update can read its own cell and its row neighbor in the same cycle.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [COST_W-1:0] ram_wdata;
  logic [AW-1:0]     rd_addr_cur, rd_addr_nbr;
  logic [COST_W-1:0] rd_cur, rd_nbr;

  gwci_ram #(
    .Width (COST_W),
    .Depth (DEPTH)
  ) u_ram_cur (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_cur),
    .rdata_o (rd_cur)
  );

  gwci_ram #(
    .Width (COST_W),
    .Depth (DEPTH)
  ) u_ram_nbr (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_nbr),
    .rdata_o (rd_nbr)
  );

  // Update of one cell: its own cost against the decayed cost of the cell
  // just before it in raster order and of the cell in the row just done.
  // With a single column that row neighbor is the previous cell itself, which
  // is still in flight to the store, so it comes from the last result.
  logic [COST_W-1:0] vert_src, side_dec, vert_dec, upd_a, upd_val;

  assign vert_src = (w_eff == DIM_W'(1)) ? prev_q : rd_nbr;
  assign side_dec = decayed(prev_q, cost_decay_q);
  assign vert_dec = decayed(vert_src, cost_decay_q);
  assign upd_a    = (stg_side_q && side_dec > rd_cur) ? side_dec : rd_cur;
  assign upd_val  = (stg_vert_q && vert_dec > upd_a) ? vert_dec : upd_a;

  // Load address: the message row is flipped to the map row.
  logic [DIM_W-1:0] load_y;
  assign load_y = h_last - in_row[DIM_W-1:0];

  logic load_we;
  assign load_we = in_xfer && (cmd_e'(in_cmd) == CMD_LOAD) && col_in && row_in;

  assign ram_we    = stg_vld_q || load_we;
  assign ram_waddr = stg_vld_q ? stg_addr_q : {load_y[YW-1:0], in_col[XW-1:0]};
  assign ram_wdata = stg_vld_q ? upd_val
                               : ((in_occ == WALL_MARK) ? wall_cost_q : '0);

  logic fwd_last, bwd_last, row_end_fwd, row_end_bwd;
  assign row_end_fwd = DIM_W'(x_q) == w_last;
  assign row_end_bwd = x_q == '0;
  assign fwd_last    = row_end_fwd && (DIM_W'(y_q) == h_last);
  assign bwd_last    = row_end_bwd && (y_q == '0);

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    stg_vld_d   = 1'b0;
    stg_addr_d  = {y_q, x_q};
    stg_side_d  = 1'b0;
    stg_vert_d  = 1'b0;
    prev_d      = stg_vld_q ? upd_val : prev_q;
    q_oob_d     = q_oob_q;
    out_vld_d   = out_vld_q && !m_axis_tready_i;
    out_cost_d  = out_cost_q;
    out_oob_d   = out_oob_q;
    rd_addr_cur = {y_q, x_q};
    rd_addr_nbr = {y_q, x_q};

    case (state_q)
      ST_IDLE: begin
        rd_addr_cur = {in_row[YW-1:0], in_col[XW-1:0]};
        if (in_xfer) begin
          case (cmd_e'(in_cmd))
            CMD_COMPUTE: begin
              x_d = '0;
              y_d = '0;
              if (w_eff == '0 || h_eff == '0) begin
                state_d = ST_END;
              end else begin
                state_d = ST_FWD;
              end
            end
            CMD_QUERY: begin
              q_oob_d = in_col_off || !col_in || !row_in;
              state_d = ST_QUERY;
            end
            default: begin
              // Loads and the unused command answer with zeros at once.
              out_vld_d  = 1'b1;
              out_cost_d = '0;
              out_oob_d  = 1'b0;
            end
          endcase
        end
      end

      ST_QUERY: begin
        out_vld_d = 1'b1;
        out_oob_d = q_oob_q;
        if (q_oob_q) begin
          out_cost_d = OUT_W'(wall_cost_q) + OUT_W'(cost_decay_q);
        end else begin
          out_cost_d = OUT_W'(rd_cur);
        end
        state_d = ST_IDLE;
      end

      ST_FWD: begin
        rd_addr_nbr = {y_q - YW'(1), x_q};
        stg_vld_d   = 1'b1;
        stg_side_d  = x_q != '0;
        stg_vert_d  = y_q != '0;
        if (fwd_last) begin
          // Prepare the backward pass from the last cell.
          x_d     = w_last[XW-1:0];
          y_d     = h_last[YW-1:0];
          state_d = ST_MID;
        end else if (row_end_fwd) begin
          x_d = '0;
          y_d = y_q + YW'(1);
        end else begin
          x_d = x_q + XW'(1);
        end
      end

      ST_MID: begin
        state_d = ST_BWD;
      end

      ST_BWD: begin
        rd_addr_nbr = {y_q + YW'(1), x_q};
        stg_vld_d   = 1'b1;
        stg_side_d  = !row_end_fwd;
        stg_vert_d  = DIM_W'(y_q) != h_last;
        if (bwd_last) begin
          state_d = ST_END;
        end else if (row_end_bwd) begin
          x_d = w_last[XW-1:0];
          y_d = y_q - YW'(1);
        end else begin
          x_d = x_q - XW'(1);
        end
      end

      ST_END: begin
        out_vld_d  = 1'b1;
        out_cost_d = '0;
        out_oob_d  = 1'b0;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      stg_vld_q <= 1'b0;
      x_q       <= '0;
      y_q       <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      stg_vld_q <= stg_vld_d;
      x_q       <= x_d;
      y_q       <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_addr_q <= stg_addr_d;
    stg_side_q <= stg_side_d;
    stg_vert_q <= stg_vert_d;
    prev_q     <= prev_d;
    q_oob_q    <= q_oob_d;
    out_cost_q <= out_cost_d;
    out_oob_q  <= out_oob_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, out_cost_q};
  assign m_axis_tuser_o  = out_oob_q;

endmodule
